// ===== rtl/core/dhcp_option_tlv_extractor_core_assert.svh =====
// Assertion macros used by the option extractor core.
`ifndef DHCP_OPTION_TLV_EXTRACTOR_CORE_ASSERT_SVH
`define DHCP_OPTION_TLV_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DHCPX_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define DHCPX_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define DHCPX_ASSERT(label, clk, rst, prop)
`define DHCPX_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/dhcpx_pkg.sv =====
`default_nettype none
package dhcpx_pkg;

  localparam int unsigned TypeWidth = 8;
  localparam int unsigned SkipWidth = 10;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [TypeWidth-1:0] WANTED_TYPE_RESET = 8'd53;
  localparam logic [SkipWidth-1:0] SKIP_BYTES_RESET  = 10'd240;
  localparam logic [7:0]           END_TYPE          = 8'd255;
  localparam logic [7:0]           PAD_TYPE          = 8'd0;

  typedef enum logic [0:0] {
    REG_WANTED_TYPE = 1'b0,
    REG_SKIP_BYTES  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_VALUE     = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_END       = 3'd2,
    KIND_EXHAUSTED = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [TypeWidth-1:0] wanted_type;
    logic [SkipWidth-1:0] skip_bytes;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/dhcpx_msg_if.sv =====
`default_nettype none
interface dhcpx_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dhcpx_res_if.sv =====
`default_nettype none
interface dhcpx_res_if import dhcpx_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_t      kind;
  logic       end_of_result;

  modport source (output valid, output out_byte, output kind, output end_of_result,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input end_of_result,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dhcpx_regs.sv =====
`default_nettype none
module dhcpx_regs import dhcpx_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic       wr_en;
  reg_index_t index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wanted_type <= WANTED_TYPE_RESET;
      cfg.skip_bytes  <= SKIP_BYTES_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_WANTED_TYPE: cfg.wanted_type <= pwdata[TypeWidth-1:0];
        REG_SKIP_BYTES:  cfg.skip_bytes  <= pwdata[SkipWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_WANTED_TYPE: prdata = {{(DataWidth-TypeWidth){1'b0}}, cfg.wanted_type};
      REG_SKIP_BYTES:  prdata = {{(DataWidth-SkipWidth){1'b0}}, cfg.skip_bytes};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/dhcpx_parse.sv =====
`default_nettype none
module dhcpx_parse import dhcpx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            step_ready,
  dhcpx_res_if.source     res
);

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LEN   = 3'd2,
    PH_VALUE = 3'd3,
    PH_IDLE  = 3'd4
  } phase_t;

  phase_t               phase, phase_next;
  logic [SkipWidth-1:0] skip_count, skip_count_next;
  logic [7:0]           value_remaining, value_remaining_next;
  logic                 is_match, is_match_next;
  logic                 produce;
  kind_t                kind_next;
  logic [7:0]           byte_next;
  logic                 eor_next;
  logic                 type_byte;

  assign step_ready = !res.valid || res.ready;

  always_comb begin
    phase_next           = phase;
    skip_count_next      = skip_count;
    value_remaining_next = value_remaining;
    is_match_next        = is_match;
    produce              = 1'b0;
    kind_next            = KIND_VALUE;
    byte_next            = '0;
    eor_next             = 1'b0;
    type_byte            = 1'b0;

    unique case (phase)
      PH_SKIP: begin
        if (skip_count < cfg.skip_bytes) begin
          skip_count_next = skip_count + 1'b1;
        end else begin
          type_byte = 1'b1;
        end
      end
      PH_TYPE: begin
        type_byte = 1'b1;
      end
      PH_LEN: begin
        value_remaining_next = data_byte;
        if (data_byte == 8'd0) begin
          if (is_match) begin
            produce    = 1'b1;
            kind_next  = KIND_EMPTY;
            eor_next   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_TYPE;
          end
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        value_remaining_next = value_remaining - 1'b1;
        if (is_match) begin
          produce   = 1'b1;
          byte_next = data_byte;
          if (value_remaining_next == 8'd0) begin
            eor_next   = 1'b1;
            phase_next = PH_IDLE;
          end
        end else if (value_remaining_next == 8'd0) begin
          phase_next = PH_TYPE;
        end
      end
      default: ;
    endcase

    if (type_byte) begin
      phase_next = PH_TYPE;
      if (data_byte == END_TYPE) begin
        produce    = 1'b1;
        kind_next  = KIND_END;
        eor_next   = 1'b1;
        phase_next = PH_IDLE;
      end else if (data_byte != PAD_TYPE) begin
        is_match_next = (data_byte == cfg.wanted_type);
        phase_next    = PH_LEN;
      end
    end

    if (last_byte) begin
      if (phase_next != PH_IDLE) begin
        produce   = 1'b1;
        kind_next = (is_match_next && (phase_next == PH_LEN || phase_next == PH_VALUE))
                    ? KIND_TRUNC : KIND_EXHAUSTED;
        byte_next = '0;
        eor_next  = 1'b1;
      end
      phase_next           = PH_SKIP;
      skip_count_next      = '0;
      value_remaining_next = '0;
      is_match_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SKIP;
      skip_count      <= '0;
      value_remaining <= '0;
      is_match        <= 1'b0;
      res.valid       <= 1'b0;
    end else begin
      if (step) begin
        phase           <= phase_next;
        skip_count      <= skip_count_next;
        value_remaining <= value_remaining_next;
        is_match        <= is_match_next;
      end
      if (step && produce) begin
        res.valid         <= 1'b1;
        res.out_byte      <= byte_next;
        res.kind          <= kind_next;
        res.end_of_result <= eor_next;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dhcp_option_tlv_extractor_core.sv =====
`default_nettype none
// Extracts the value of one DHCP option from a message that arrives one byte per word,
// with last_byte set on the final byte. After skip_bytes bytes (reset 240) it walks the
// options and emits each value byte of the first option whose code equals wanted_type
// (reset 53). A single status word reports an empty value, the end option, an exhausted
// message or a value cut short by the last byte. A pad byte is one byte long, and codes
// 0 and 255 never match. The block takes one byte per clock cycle while its result words
// are taken; a byte passes an input register and then the parser, whose result register
// holds its word. While a word waits to be taken, at most one more byte is accepted and
// the input then stalls until the word is taken.
// Registers are written through the APB port at byte addresses 0 and 4; the user must
// write them only while the block is idle, which the block itself does not enforce.
module dhcp_option_tlv_extractor_core import dhcpx_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  dhcpx_msg_if.sink                 msg,
  dhcpx_res_if.source               res,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic       step_ready;
  logic       step;

  assign step      = in_valid && step_ready;
  assign msg.ready = !in_valid || step_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
      in_data  <= msg.data_byte;
      in_last  <= msg.last_byte;
    end
  end

  dhcpx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhcpx_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (step),
    .data_byte  (in_data),
    .last_byte  (in_last),
    .step_ready (step_ready),
    .res        (res)
  );

`include "dhcp_option_tlv_extractor_core_assert.svh"

  `DHCPX_ASSERT(a_status_final, clk, rst, res.valid && res.kind != KIND_VALUE |-> res.end_of_result)
  `DHCPX_ASSERT(a_status_zero, clk, rst, res.valid && res.kind != KIND_VALUE |-> res.out_byte == 8'd0)
  `DHCPX_ASSERT(a_kind_range, clk, rst, res.valid |-> res.kind <= KIND_TRUNC)
  `DHCPX_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res.valid && !in_valid)

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dhcpx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    ST_SKIP  = 3'd0,
    ST_TYPE  = 3'd1,
    ST_LEN   = 3'd2,
    ST_VALUE = 3'd3,
    ST_IDLE  = 3'd4
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       eor;
  } option_word_t;

  typedef logic [7:0] bytes_t [$];

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic pready;

  dhcpx_msg_if msg_if ();
  dhcpx_res_if res_if ();

  dhcp_option_tlv_extractor_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  msg_word_t    pending_bytes [$];
  option_word_t option_words [$];

  logic [7:0]   want_type;
  logic [9:0]   skip_len;
  parse_state_t pstate;
  logic [9:0]   skipped;
  logic [7:0]   remain;
  logic         hit_opt;

  int  queued_cnt;
  int  accepted_cnt;
  int  fail_cnt;
  int  cycle_cnt;
  int  src_pct;
  int  snk_pct;
  int  src_gap;
  int  snk_gap;
  bit  msg_taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic parse_option_byte(input logic [7:0] b, input logic lst);
    bit           hit;
    option_word_t w;
    hit = 1'b0;
    w = '{out_byte: 8'd0, kind: KIND_VALUE, eor: 1'b0};
    if (pstate == ST_SKIP) begin
      if (skipped < skip_len) begin
        skipped = skipped + 10'd1;
      end else begin
        pstate = ST_TYPE;
      end
    end
    case (pstate)
      ST_TYPE: begin
        if (b == END_TYPE) begin
          hit = 1'b1;
          w.kind = KIND_END;
          w.eor = 1'b1;
          pstate = ST_IDLE;
        end else if (b != PAD_TYPE) begin
          hit_opt = (b == want_type);
          pstate = ST_LEN;
        end
      end
      ST_LEN: begin
        remain = b;
        if (hit_opt && b == 8'd0) begin
          hit = 1'b1;
          w.kind = KIND_EMPTY;
          w.eor = 1'b1;
          pstate = ST_IDLE;
        end else if (b == 8'd0) begin
          pstate = ST_TYPE;
        end else begin
          pstate = ST_VALUE;
        end
      end
      ST_VALUE: begin
        remain = remain - 8'd1;
        if (hit_opt) begin
          hit = 1'b1;
          w.kind = KIND_VALUE;
          w.out_byte = b;
          if (remain == 8'd0) begin
            w.eor = 1'b1;
            pstate = ST_IDLE;
          end
        end else if (remain == 8'd0) begin
          pstate = ST_TYPE;
        end
      end
      default: begin
      end
    endcase
    if (lst) begin
      if (pstate != ST_IDLE) begin
        hit = 1'b1;
        w.kind = (hit_opt && (pstate == ST_LEN || pstate == ST_VALUE)) ?
                 KIND_TRUNC : KIND_EXHAUSTED;
        w.out_byte = 8'd0;
        w.eor = 1'b1;
      end
      pstate = ST_SKIP;
      skipped = 10'd0;
      remain = 8'd0;
      hit_opt = 1'b0;
    end
    if (hit) begin
      option_words.push_back(w);
    end
  endtask

  task automatic check_option_word();
    option_word_t w;
    if (option_words.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("unexpected word: byte %h kind %0d end %0b",
                 res_if.out_byte, res_if.kind, res_if.end_of_result);
      end
    end else begin
      w = option_words.pop_front();
      if (res_if.out_byte !== w.out_byte || res_if.kind !== w.kind ||
          res_if.end_of_result !== w.eor) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("mismatch: expected byte %h kind %0d end %0b, got byte %h kind %0d end %0b",
                   w.out_byte, w.kind, w.eor,
                   res_if.out_byte, res_if.kind, res_if.end_of_result);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    msg_taken = 1'b0;
    if (!rst) begin
      if (msg_if.valid && msg_if.ready) begin
        msg_taken = 1'b1;
        accepted_cnt++;
        parse_option_byte(msg_if.data_byte, msg_if.last_byte);
      end
      if (res_if.valid && res_if.ready) begin
        check_option_word();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_msg
    msg_word_t w;
    if (rst) begin
      msg_if.valid <= 1'b0;
    end else if (!msg_if.valid || msg_taken) begin
      if (src_gap != 0) begin
        src_gap--;
        msg_if.valid <= 1'b0;
      end else if (src_pct != 0 && $urandom_range(99) < src_pct) begin
        src_gap = $urandom_range(13, 1) - 1;
        msg_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        w = pending_bytes.pop_front();
        msg_if.valid <= 1'b1;
        msg_if.data_byte <= w.data;
        msg_if.last_byte <= w.last;
      end else begin
        msg_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      res_if.ready <= 1'b0;
    end else if (snk_pct != 0 && $urandom_range(99) < snk_pct) begin
      snk_gap = $urandom_range(13, 1) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || option_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [DataWidth-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(4 * int'(idx));
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] wt, input logic [9:0] sk);
    logic [DataWidth-1:0] v;
    wait_drained();
    v = $urandom;
    v[7:0] = wt;
    apb_write(REG_WANTED_TYPE, v);
    want_type = wt;
    v = $urandom;
    v[9:0] = sk;
    apb_write(REG_SKIP_BYTES, v);
    skip_len = sk;
    @(posedge clk);
  endtask

  task automatic send_msg(input bytes_t m);
    msg_word_t w;
    foreach (m[i]) begin
      w.data = m[i];
      w.last = (i == m.size() - 1);
      pending_bytes.push_back(w);
      queued_cnt++;
    end
  endtask

  // Mostly well-formed option lists; the rest is cut short or plain noise.
  task automatic random_message(input bit tidy);
    bytes_t     m;
    int         pick;
    int         n_opt;
    int         want_at;
    int         len;
    int         cut;
    logic [7:0] t;
    pick = tidy ? 99 : $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(12, 1)) m.push_back(8'($urandom));
    end else begin
      repeat (int'(skip_len)) m.push_back(8'($urandom));
      n_opt = $urandom_range(5, 0);
      want_at = (tidy || $urandom_range(9) < 6) ? $urandom_range(n_opt, 0) : -1;
      for (int i = 0; i <= n_opt; i++) begin
        if (i == want_at) begin
          t = want_type;
          len = ($urandom_range(39) == 0) ? $urandom_range(255, 9) : $urandom_range(8, 0);
        end else if ($urandom_range(5) == 0) begin
          m.push_back(PAD_TYPE);
          continue;
        end else begin
          t = 8'($urandom_range(254, 1));
          if (t == want_type) begin
            t = (t == 8'd254) ? 8'd1 : t + 8'd1;
          end
          len = $urandom_range(6, 0);
        end
        m.push_back(t);
        m.push_back(8'(len));
        repeat (len) m.push_back(8'($urandom));
      end
      if ($urandom_range(1) == 1) begin
        m.push_back(END_TYPE);
      end
      repeat ($urandom_range(3, 0)) m.push_back(8'($urandom));
      if (pick < 30 && m.size() > 1) begin
        cut = $urandom_range(m.size(), 1);
        while (m.size() > cut) void'(m.pop_back());
      end
    end
    if (m.size() == 0) begin
      m.push_back(8'($urandom));
    end
    send_msg(m);
  endtask

  task automatic run_phase(input logic [7:0] wt, input logic [9:0] sk, input int budget,
                           input int src, input int snk, input bit tidy);
    int start;
    apply_config(wt, sk);
    src_pct = src;
    snk_pct = snk;
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      random_message(tidy);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    msg_if.valid = 1'b0;
    msg_if.data_byte = 8'd0;
    msg_if.last_byte = 1'b0;
    res_if.ready = 1'b0;
    want_type = WANTED_TYPE_RESET;
    skip_len = SKIP_BYTES_RESET;
    pstate = ST_SKIP;
    skipped = 10'd0;
    remain = 8'd0;
    hit_opt = 1'b0;
    queued_cnt = 0;
    accepted_cnt = 0;
    fail_cnt = 0;
    cycle_cnt = 0;
    src_pct = 10;
    snk_pct = 10;
    src_gap = 0;
    snk_gap = 0;
    msg_taken = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One full-size message under the reset values.
    random_message(1'b1);

    apply_config(8'd53, 10'd0);
    send_msg('{8'd53, 8'd1, 8'hFF, 8'd255});
    send_msg('{8'd0, 8'd53, 8'd0});
    send_msg('{8'd255});
    send_msg('{8'd7, 8'd1, 8'd0});
    send_msg('{8'd53, 8'd3, 8'h5A, 8'hA5});
    send_msg('{8'd53});
    send_msg('{8'd53, 8'd2});
    send_msg('{8'd9, 8'd0, 8'd255});
    apply_config(8'd53, 10'd3);
    send_msg('{8'hAB});
    send_msg('{8'd1, 8'd2, 8'd3, 8'd53, 8'd1, 8'h80});

    run_phase(8'd53, 10'd0, 20, 0, 0, 1'b0);
    run_phase(8'($urandom_range(254, 1)), 10'($urandom_range(8, 1)), 15, 10, 10, 1'b0);
    run_phase(PAD_TYPE, 10'd2, 12, 30, 5, 1'b0);
    run_phase(END_TYPE, 10'd1, 12, 5, 30, 1'b0);
    run_phase(8'd1, 10'd4, 15, 20, 20, 1'b0);
    run_phase(8'($urandom_range(254, 1)), 10'($urandom_range(6, 0)), 15, 30, 30, 1'b0);
    apply_config(8'd254, 10'd1023);
    send_msg('{8'd254, 8'd1, 8'h11});
    run_phase(8'($urandom_range(254, 1)), 10'($urandom_range(5, 0)), 30, 0, 0, 1'b0);

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
